@@ hdl/silog_pkg.sv @@
// ----------------------------------------------------------------------------
// silog_pkg
// shared widths, queue item type and log table generator
// ----------------------------------------------------------------------------
package silog_pkg;

  localparam int MAX_PAIRS_DEF      = 1048576;
  localparam int LOG_TABLE_SIZE_DEF = 256;

  localparam int VAL_W    = 32;   // prediction, target, loss
  localparam int SHIFT_W  = 16;   // log_shift register
  localparam int USED_W   = 21;   // pairs_used port
  localparam int LN_W     = 22;   // signed q5.16 log
  localparam int D_W      = 22;   // signed log difference
  localparam int AD_W     = 21;   // magnitude of difference
  localparam int SQ_W     = 42;   // squared difference
  localparam int DS_W     = 42;   // signed running sum
  localparam int SS_W     = 61;   // running sum of squares
  localparam int MM_W     = 82;   // square of the mean magnitude
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = 2;

  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 16'd7;
  localparam int unsigned        LN2_Q16     = 45426;
  localparam longint unsigned    LN2_Q32     = 64'd2977044472;
  localparam logic [DS_W-1:0]    DS_MAX      = {1'b0, {(DS_W-1){1'b1}}};
  localparam logic [SS_W-1:0]    SS_MAX      = {SS_W{1'b1}};

  typedef struct packed {
    logic signed [D_W-1:0] d;
    logic [SQ_W-1:0]       sq;
    logic                  last;
  } silog_item_t;

  // position of the leading one, zero for an all-zero word
  function automatic logic [5:0] lead_pos(input logic [32:0] v);
    logic [5:0] p;
    p = 6'd0;
    for (int i = 0; i < 33; i++) begin
      if (v[i]) p = 6'(i);
    end
    return p;
  endfunction

  // round(ln(1 + i/size) * 2^16) by repeated squaring of the mantissa
  function automatic logic [15:0] log_entry(input int unsigned i, input int unsigned size);
    longint unsigned num;
    longint unsigned rem;
    longint unsigned z;
    longint unsigned l2;
    longint unsigned lnq;
    num = longint'(size + i) << 30;
    rem = 64'd0;
    z   = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      rem = (rem << 1) | ((num >> b) & 64'd1);
      z   = z << 1;
      if (rem >= longint'(size)) begin
        rem = rem - longint'(size);
        z   = z | 64'd1;
      end
    end
    l2 = 64'd0;
    for (int k = 0; k < 32; k++) begin
      z  = (z * z) >> 30;
      l2 = l2 << 1;
      if (z >= (64'd1 << 31)) begin
        z  = z >> 1;
        l2 = l2 | 64'd1;
      end
    end
    lnq = (l2 * LN2_Q32) >> 32;
    return 16'((lnq + 64'd32768) >> 16);
  endfunction

endpackage

@@ hdl/silog_front.sv @@
// ----------------------------------------------------------------------------
// silog_front
// log pipeline: offset, leading one, table lookup, difference and square
// ----------------------------------------------------------------------------
module silog_front #(
  parameter int LOG_TABLE_SIZE = silog_pkg::LOG_TABLE_SIZE_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [silog_pkg::SHIFT_W-1:0]   log_shift,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [silog_pkg::VAL_W-1:0]     prediction,
  input  logic [silog_pkg::VAL_W-1:0]     target,
  input  logic                            last,
  output logic                            push,
  input  logic                            q_ready,
  output silog_pkg::silog_item_t          push_item
);

  localparam int IW = (LOG_TABLE_SIZE > 1) ? $clog2(LOG_TABLE_SIZE) : 1;
  localparam int PW = 32 + $clog2(LOG_TABLE_SIZE + 1);

  logic [15:0] rom [LOG_TABLE_SIZE];

  for (genvar gi = 0; gi < LOG_TABLE_SIZE; gi++) begin : g_rom
    localparam logic [15:0] ENTRY = silog_pkg::log_entry(gi, LOG_TABLE_SIZE);
    assign rom[gi] = ENTRY;
  end

  logic adv;
  logic s1_valid, s2_valid, s3_valid, s4_valid;
  logic s1_last, s2_last, s3_last, s4_last;
  logic [31:0] s1_pred, s1_targ;
  logic [32:0] s2_vp, s2_vt;
  logic [5:0]  s2_pp, s2_pt;
  logic signed [silog_pkg::LN_W-1:0] s3_lnp, s3_lnt;
  logic signed [silog_pkg::D_W-1:0]  s4_d;
  logic [silog_pkg::AD_W-1:0]        s4_ad;

  logic [32:0] vp, vt;
  logic signed [silog_pkg::LN_W-1:0] lnp, lnt;
  logic signed [silog_pkg::D_W-1:0]  d;

  // whole pipeline holds while its last stage waits on a full queue
  assign adv      = !(s4_valid && !q_ready);
  assign in_ready = adv;
  assign push     = s4_valid && q_ready;

  assign vp = 33'(s1_pred) + 33'(log_shift);
  assign vt = 33'(s1_targ) + 33'(log_shift);

  function automatic logic signed [silog_pkg::LN_W-1:0] ln_of(
    input logic [32:0] v, input logic [5:0] p, input logic [15:0] tab [LOG_TABLE_SIZE]);
    logic [64:0]   sh;
    logic [31:0]   f;
    logic [PW-1:0] pr;
    logic [IW-1:0] idx;
    logic signed [6:0] e;
    sh  = {32'b0, v} << (6'd32 - p);
    f   = sh[31:0];
    pr  = PW'(f) * PW'(LOG_TABLE_SIZE);
    idx = IW'(pr >> 32);
    e   = $signed({1'b0, p}) - 7'sd16;
    return silog_pkg::LN_W'(e) * silog_pkg::LN_W'(silog_pkg::LN2_Q16)
           + $signed({{(silog_pkg::LN_W-16){1'b0}}, tab[idx]});
  endfunction

  assign lnp = ln_of(s2_vp, s2_pp, rom);
  assign lnt = ln_of(s2_vt, s2_pt, rom);
  assign d   = s3_lnp - s3_lnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pred <= prediction;
      s1_targ <= target;
      s1_last <= last;
      s2_vp   <= vp;
      s2_vt   <= vt;
      s2_pp   <= silog_pkg::lead_pos(vp);
      s2_pt   <= silog_pkg::lead_pos(vt);
      s2_last <= s1_last;
      s3_lnp  <= lnp;
      s3_lnt  <= lnt;
      s3_last <= s2_last;
      s4_d    <= d;
      s4_ad   <= d[silog_pkg::D_W-1] ? silog_pkg::AD_W'(-d) : silog_pkg::AD_W'(d);
      s4_last <= s3_last;
    end
  end

  assign push_item.d    = s4_d;
  assign push_item.sq   = silog_pkg::SQ_W'(s4_ad) * silog_pkg::SQ_W'(s4_ad);
  assign push_item.last = s4_last;

endmodule

@@ hdl/silog_queue.sv @@
// ----------------------------------------------------------------------------
// silog_queue
// small fifo between the log pipeline and the accumulator
// ----------------------------------------------------------------------------
module silog_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  silog_pkg::silog_item_t push_item,
  output logic                   q_ready,
  output logic                   q_valid,
  input  logic                   pop,
  output silog_pkg::silog_item_t pop_item
);

  silog_pkg::silog_item_t mem [silog_pkg::QDEPTH];
  logic [silog_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [silog_pkg::QPTR_W:0]   count;

  assign q_ready  = count != (silog_pkg::QPTR_W+1)'(silog_pkg::QDEPTH);
  assign q_valid  = count != '0;
  assign pop_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (!push && pop) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

endmodule

@@ hdl/silog_back.sv @@
// ----------------------------------------------------------------------------
// silog_back
// accumulators, serial dividers, split squaring and result register
// ----------------------------------------------------------------------------
module silog_back #(
  parameter int MAX_PAIRS = silog_pkg::MAX_PAIRS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_valid,
  output logic                            pop,
  input  silog_pkg::silog_item_t          pop_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [silog_pkg::VAL_W-1:0]     loss,
  output logic [silog_pkg::USED_W-1:0]    pairs_used
);

  localparam int CW = $clog2(MAX_PAIRS + 1);
  localparam int SS = silog_pkg::SS_W;

  typedef enum logic [4:0] {
    ST_ACC = 5'b00001,
    ST_DIV = 5'b00010,
    ST_SQR = 5'b00100,
    ST_FIN = 5'b01000,
    ST_OUT = 5'b10000
  } state_t;

  state_t state;
  logic [CW-1:0]                        pair_count;
  logic signed [silog_pkg::DS_W-1:0]    diff_sum;
  logic [SS-1:0]                        square_sum;
  logic [CW-1:0]                        count_next;
  logic signed [silog_pkg::DS_W-1:0]    diff_next;
  logic [SS-1:0]                        square_next;
  logic signed [silog_pkg::DS_W:0]      dsum;
  logic [SS:0]                          ssum;
  logic                                 room;

  logic [CW-1:0]  divisor;
  logic [SS-1:0]  num_sq, num_ds;
  logic [CW-1:0]  rem_sq, rem_ds;
  logic [CW:0]    trial_sq, trial_ds;
  logic [5:0]     step;
  logic [1:0]     mstep;
  logic [41:0]    prod;
  logic [silog_pkg::MM_W-1:0] mm;
  logic [SS-1:0]  lq;
  logic [silog_pkg::MM_W-1:0] half;
  logic [SS:0]    rnd;
  logic [63:0]    count_wide;

  assign room = pair_count < CW'(MAX_PAIRS);
  assign pop  = (state == ST_ACC) && q_valid;

  always_comb begin
    dsum = (silog_pkg::DS_W+1)'(diff_sum) + (silog_pkg::DS_W+1)'($signed(pop_item.d));
    ssum = (SS+1)'(square_sum) + (SS+1)'(pop_item.sq);
    count_next  = pair_count;
    diff_next   = diff_sum;
    square_next = square_sum;
    if (room) begin
      count_next = pair_count + 1'b1;
      if (dsum > $signed((silog_pkg::DS_W+1)'(silog_pkg::DS_MAX)))
        diff_next = silog_pkg::DS_MAX;
      else if (dsum < -$signed((silog_pkg::DS_W+1)'(silog_pkg::DS_MAX)))
        diff_next = -silog_pkg::DS_MAX;
      else
        diff_next = silog_pkg::DS_W'(dsum);
      square_next = ssum[SS] ? silog_pkg::SS_MAX : ssum[SS-1:0];
    end
  end

  assign trial_sq = {rem_sq, num_sq[SS-1]};
  assign trial_ds = {rem_ds, num_ds[SS-1]};
  assign half     = mm >> 1;
  assign rnd      = (SS+1)'(lq) + (SS+1)'(32768);
  assign count_wide = 64'(pair_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_ACC;
      pair_count <= '0;
      diff_sum   <= '0;
      square_sum <= '0;
      out_valid  <= 1'b0;
    end else begin
      if ((state == ST_OUT) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_ACC: begin
          if (pop) begin
            pair_count <= count_next;
            diff_sum   <= diff_next;
            square_sum <= square_next;
            if (pop_item.last) state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (step == 6'(SS - 1)) state <= ST_SQR;
        end
        ST_SQR: begin
          if (mstep == 2'd3) state <= ST_FIN;
        end
        ST_FIN: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            pair_count <= '0;
            diff_sum   <= '0;
            square_sum <= '0;
            state      <= ST_ACC;
          end
        end
        default: state <= ST_ACC;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_ACC: begin
        divisor <= (count_next == '0) ? CW'(1) : count_next;
        num_sq  <= square_next;
        num_ds  <= SS'(diff_next[silog_pkg::DS_W-1] ? -diff_next : diff_next);
        rem_sq  <= '0;
        rem_ds  <= '0;
        step    <= '0;
        mstep   <= '0;
      end
      ST_DIV: begin
        step <= step + 1'b1;
        if (trial_sq >= (CW+1)'(divisor)) begin
          rem_sq <= CW'(trial_sq - (CW+1)'(divisor));
          num_sq <= {num_sq[SS-2:0], 1'b1};
        end else begin
          rem_sq <= trial_sq[CW-1:0];
          num_sq <= {num_sq[SS-2:0], 1'b0};
        end
        if (trial_ds >= (CW+1)'(divisor)) begin
          rem_ds <= CW'(trial_ds - (CW+1)'(divisor));
          num_ds <= {num_ds[SS-2:0], 1'b1};
        end else begin
          rem_ds <= trial_ds[CW-1:0];
          num_ds <= {num_ds[SS-2:0], 1'b0};
        end
      end
      ST_SQR: begin
        // m = hi * 2^21 + lo, squared in three partial products
        mstep <= mstep + 1'b1;
        case (mstep)
          2'd0: begin
            prod <= 42'(num_ds[20:0]) * 42'(num_ds[20:0]);
          end
          2'd1: begin
            mm   <= silog_pkg::MM_W'(prod);
            prod <= 42'(num_ds[40:21]) * 42'(num_ds[20:0]);
          end
          2'd2: begin
            mm   <= mm + (silog_pkg::MM_W'(prod) << 22);
            prod <= 42'(num_ds[40:21]) * 42'(num_ds[40:21]);
          end
          default: begin
            mm <= mm + (silog_pkg::MM_W'(prod) << 42);
          end
        endcase
      end
      ST_FIN: begin
        lq <= (half > silog_pkg::MM_W'(num_sq)) ? '0 : SS'(silog_pkg::MM_W'(num_sq) - half);
      end
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          loss       <= (rnd[SS:48] != '0) ? '1 : rnd[47:16];
          pairs_used <= count_wide[silog_pkg::USED_W-1:0];
        end
      end
      default: begin
        step <= '0;
      end
    endcase
  end

endmodule

@@ hdl/scale_invariant_log_loss.sv @@
// ----------------------------------------------------------------------------
// scale_invariant_log_loss
// streaming scale invariant log loss, lambda one half, q16.16 in and out
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid/in_ready with prediction, target and last; one
//   request per cycle is taken while the internal queue has room
//   config channel: cfg_valid/cfg_ready with cfg_data, the log offset;
//   always ready, write it only while the block is idle
//   output channel: out_valid/out_ready with loss and pairs_used; one
//   request appears for each input marked last, none for the others
// flow
//   a pair passes through the log pipeline, then the queue, then the
//   accumulator; pairs flow at one per cycle while the queue has room
//   on a last pair the back end runs a bit serial divide, split squaring
//   and a subtract, then loads the result register and raises out_valid
// reset
//   clears the accumulators, the pipeline, the queue and out_valid;
//   the log offset returns to 7
// stall
//   a stalled receiver holds the finished result; the back end waits in its
//   output step and the front keeps filling the queue until it is full
// ----------------------------------------------------------------------------
module scale_invariant_log_loss #(
  parameter int MAX_PAIRS      = silog_pkg::MAX_PAIRS_DEF,
  parameter int LOG_TABLE_SIZE = silog_pkg::LOG_TABLE_SIZE_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [silog_pkg::SHIFT_W-1:0]   cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [silog_pkg::VAL_W-1:0]     prediction,
  input  logic [silog_pkg::VAL_W-1:0]     target,
  input  logic                            last,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [silog_pkg::VAL_W-1:0]     loss,
  output logic [silog_pkg::USED_W-1:0]    pairs_used
);

  // offset added to each operand before the log
  logic [silog_pkg::SHIFT_W-1:0] log_shift;

  // front to queue
  logic                   push;
  logic                   q_ready;
  silog_pkg::silog_item_t push_item;

  // queue to back
  logic                   q_valid;
  logic                   pop;
  silog_pkg::silog_item_t pop_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      log_shift <= silog_pkg::SHIFT_RESET;
    end else if (cfg_valid) begin
      log_shift <= cfg_data;
    end
  end

  // log of both operands, difference and its square
  silog_front #(
    .LOG_TABLE_SIZE(LOG_TABLE_SIZE)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .log_shift (log_shift),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .prediction(prediction),
    .target    (target),
    .last      (last),
    .push      (push),
    .q_ready   (q_ready),
    .push_item (push_item)
  );

  // decouples the pipeline from the long final computation
  silog_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(push_item),
    .q_ready  (q_ready),
    .q_valid  (q_valid),
    .pop      (pop),
    .pop_item (pop_item)
  );

  // accumulate and form the loss on the last pair
  silog_back #(
    .MAX_PAIRS(MAX_PAIRS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .pop       (pop),
    .pop_item  (pop_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .loss      (loss),
    .pairs_used(pairs_used)
  );

endmodule

@@ test/scale_invariant_log_loss_tb.sv @@
// ----------------------------------------------------------------------------
// scale_invariant_log_loss_tb
// streams prediction/target sets through the loss block under random idling
// and a long receiver hold-off, predicts every loss and pair count locally
// and compares each output request against the oldest pending expected result
// ----------------------------------------------------------------------------
module scale_invariant_log_loss_tb;

  localparam int               TBL_N   = 256;
  localparam int unsigned      N_LIMIT = 1048576;
  localparam longint           SUM_LIM = (64'sd1 <<< 41) - 1;
  localparam longint unsigned  SQS_LIM = (64'd1 << 61) - 1;

  typedef struct {
    logic [silog_pkg::VAL_W-1:0]  pred;
    logic [silog_pkg::VAL_W-1:0]  targ;
    logic                         lst;
    logic                         typed;   // expected result written in the row
    logic [silog_pkg::VAL_W-1:0]  t_loss;
    logic [silog_pkg::USED_W-1:0] t_used;
  } stim_row_t;

  logic                          clk;
  logic                          rst;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [silog_pkg::SHIFT_W-1:0] cfg_data;
  logic                          in_valid;
  logic                          in_ready;
  logic [silog_pkg::VAL_W-1:0]   prediction;
  logic [silog_pkg::VAL_W-1:0]   target;
  logic                          last;
  logic                          out_valid;
  logic                          out_ready;
  logic [silog_pkg::VAL_W-1:0]   loss;
  logic [silog_pkg::USED_W-1:0]  pairs_used;

  scale_invariant_log_loss uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .prediction(prediction), .target(target), .last(last),
    .out_valid(out_valid), .out_ready(out_ready),
    .loss(loss), .pairs_used(pairs_used)
  );

  // predictor state
  longint                        mant_lut [TBL_N];
  logic [silog_pkg::SHIFT_W-1:0] pm_shift;
  int unsigned                   pm_count;
  longint                        pm_dsum;
  longint unsigned               pm_sqsum;

  // pending results
  logic [silog_pkg::VAL_W-1:0]  loss_due [$];
  logic [silog_pkg::USED_W-1:0] used_due [$];

  int  errors;
  bit  quiet;          // no idling on either side
  int  hold_req;       // bumped to ask for a long receiver hold-off
  int  hold_seen;
  int  hold_left;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    #5000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // mantissa table: 32 log2 fraction bits by repeated squaring, times ln2
  task automatic fill_lut();
    longint unsigned z, l2, lnq;
    for (int i = 0; i < TBL_N; i++) begin
      z  = ((64'(TBL_N) + 64'(i)) << 30) / 64'(TBL_N);
      l2 = 0;
      for (int k = 0; k < 32; k++) begin
        z  = (z * z) >> 30;
        l2 = l2 << 1;
        if (z >= (64'd1 << 31)) begin
          z  = z >> 1;
          l2 = l2 | 64'd1;
        end
      end
      lnq = (l2 * 64'd2977044472) >> 32;
      mant_lut[i] = longint'((lnq + 64'd32768) >> 16);
    end
  endtask

  // q5.16 natural log of value plus offset
  function automatic longint q16_ln(logic [silog_pkg::VAL_W-1:0] x);
    logic [32:0]     v;
    int              p;
    longint unsigned f;
    v = {1'b0, x} + 33'(pm_shift);
    if (v == 0) return -16 * longint'(silog_pkg::LN2_Q16);
    p = 0;
    for (int i = 0; i < 33; i++)
      if (v[i]) p = i;
    f = (64'(v) << (32 - p)) & 64'hFFFF_FFFF;
    return longint'(p - 16) * longint'(silog_pkg::LN2_Q16) + mant_lut[f[31:24]];
  endfunction

  // fold one pair into the running sums; on last return loss and count
  function automatic bit fold_pair(logic [silog_pkg::VAL_W-1:0] pr,
                                   logic [silog_pkg::VAL_W-1:0] tg,
                                   logic lst, output logic [silog_pkg::VAL_W-1:0] lo,
                                   output logic [silog_pkg::USED_W-1:0] used);
    longint          d;
    longint unsigned ad, sq, n, q, mag, m, half, lq, lv;
    lo = '0;
    used = '0;
    if (pm_count < N_LIMIT) begin
      d  = q16_ln(pr) - q16_ln(tg);
      ad = (d < 0) ? longint'(-d) : longint'(d);
      sq = ad * ad;
      pm_count++;
      pm_dsum += d;
      if (pm_dsum > SUM_LIM) pm_dsum = SUM_LIM;
      if (pm_dsum < -SUM_LIM) pm_dsum = -SUM_LIM;
      if (sq > SQS_LIM - pm_sqsum) pm_sqsum = SQS_LIM;
      else pm_sqsum += sq;
    end
    if (!lst) return 0;
    n    = (pm_count == 0) ? 1 : pm_count;
    q    = pm_sqsum / n;
    mag  = (pm_dsum < 0) ? longint'(-pm_dsum) : longint'(pm_dsum);
    m    = mag / n;
    half = (m * m) >> 1;
    lq   = (half > q) ? 0 : q - half;
    lv   = (lq + 64'd32768) >> 16;
    if (lv > 64'hFFFF_FFFF) lv = 64'hFFFF_FFFF;
    lo   = lv[silog_pkg::VAL_W-1:0];
    used = pm_count[silog_pkg::USED_W-1:0];
    pm_count = 0;
    pm_dsum  = 0;
    pm_sqsum = 0;
    return 1;
  endfunction

  // offer one pair; returns at the edge that takes it
  task automatic push_pair(stim_row_t r);
    logic [silog_pkg::VAL_W-1:0]  lo;
    logic [silog_pkg::USED_W-1:0] used;
    if (!quiet && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    prediction <= r.pred;
    target     <= r.targ;
    last       <= r.lst;
    do @(posedge clk); while (!in_ready);
    if (fold_pair(r.pred, r.targ, r.lst, lo, used)) begin
      loss_due.push_back(r.typed ? r.t_loss : lo);
      used_due.push_back(r.typed ? r.t_used : used);
    end
  endtask

  // sender stops until every request has come back, then lets the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (loss_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_shift(logic [silog_pkg::SHIFT_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pm_shift = v;
  endtask

  // random operand, biased toward the edges of the range
  function automatic logic [silog_pkg::VAL_W-1:0] pick_val(
    logic [silog_pkg::VAL_W-1:0] near);
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return silog_pkg::VAL_W'($urandom_range(0, 255));
      3: return silog_pkg::VAL_W'(1) << $urandom_range(0, 31);
      4: return $urandom() >> $urandom_range(0, 31);
      5: return near + silog_pkg::VAL_W'($urandom_range(0, 4096)) - silog_pkg::VAL_W'(2048);
      default: return $urandom();
    endcase
  endfunction

  // random sets, mostly short, ending with last
  task automatic run_sets(int items);
    stim_row_t r;
    int        len;
    r.typed = 1'b0;
    r.t_loss = '0;
    r.t_used = '0;
    while (items > 0) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      for (int k = 0; k < len; k++) begin
        r.pred = $urandom();
        r.pred = pick_val(r.pred);
        r.targ = pick_val(r.pred);
        r.lst  = (k == len - 1);
        push_pair(r);
        items--;
      end
    end
  endtask

  // output side: random backpressure, long hold-off on request, checking
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_seen <= 0;
    end else begin
      if (hold_req != hold_seen) begin
        hold_seen <= hold_req;
        hold_left <= 400;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= quiet || ($urandom_range(99) >= 25);
      end
      if (out_valid && out_ready) begin
        if (loss_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected request: loss %h pairs_used %0d", loss, pairs_used);
        end else begin
          if (loss !== loss_due[0] || pairs_used !== used_due[0]) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: loss exp %h got %h, pairs_used exp %0d got %0d",
                       loss_due[0], loss, used_due[0], pairs_used);
          end
          void'(loss_due.pop_front());
          void'(used_due.pop_front());
        end
      end
    end
  end

  // main sequence
  initial begin
    stim_row_t dir_tab [$];
    errors = 0;
    quiet = 1'b0;
    hold_req = 0;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    prediction = '0;
    target = '0;
    last = 1'b0;
    pm_shift = silog_pkg::SHIFT_RESET;
    pm_count = 0;
    pm_dsum = 0;
    pm_sqsum = 0;
    fill_lut();

    // equal operands give zero loss over one pair; the other rows use predicted results
    dir_tab = '{
      '{32'h0001_0000, 32'h0001_0000, 1'b1, 1'b1, 32'h0, 21'd1},
      '{32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h0, 21'd1},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0, 21'd1},
      '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0, 21'd0},
      '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, 32'h0, 21'd0},
      '{32'h0001_0000, 32'h0002_0000, 1'b0, 1'b0, 32'h0, 21'd0},
      '{32'h0003_0000, 32'h0001_0000, 1'b0, 1'b0, 32'h0, 21'd0},
      '{32'h0000_0001, 32'h0000_0001, 1'b1, 1'b0, 32'h0, 21'd0},
      '{32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 1'b0, 32'h0, 21'd0},
      '{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b0, 32'h0, 21'd0},
      '{32'h8000_0000, 32'h0000_0001, 1'b0, 1'b0, 32'h0, 21'd0},
      '{32'h7FFF_FFFF, 32'h0000_8000, 1'b1, 1'b0, 32'h0, 21'd0},
      '{32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0, 21'd0},
      '{32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0, 21'd0},
      '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, 32'h0, 21'd0}
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows at the reset offset
    foreach (dir_tab[i]) push_pair(dir_tab[i]);
    drain();

    // zero offset: zero operands hit the one-lsb log
    write_shift('0);
    dir_tab[0] = '{32'h0, 32'h0, 1'b1, 1'b1, 32'h0, 21'd1};
    push_pair(dir_tab[0]);
    run_sets(140);
    drain();

    // full offset, receiver holds off while the sender keeps offering
    write_shift('1);
    hold_req <= hold_req + 1;
    run_sets(150);
    drain();

    // random offset, long stretch without idling
    write_shift(silog_pkg::SHIFT_W'($urandom()));
    quiet = 1'b1;
    run_sets(150);
    drain();
    quiet = 1'b0;

    write_shift(silog_pkg::SHIFT_W'(1));
    run_sets(150);
    drain();

    write_shift(silog_pkg::SHIFT_RESET);
    run_sets(150);
    drain();

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
